[rtl/quad_rotate_project_bbox_defines.svh]
// ----------------------------------------------------------------------------
// quad_rotate_project_bbox_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef QUAD_ROTATE_PROJECT_BBOX_DEFINES_SVH
`define QUAD_ROTATE_PROJECT_BBOX_DEFINES_SVH

// same-cycle implication, disabled during reset
`define QRP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("qrp check failed");

// next-cycle implication, disabled during reset
`define QRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("qrp check failed");

`endif

[rtl/qrp_pkg.sv]
// ----------------------------------------------------------------------------
// qrp_pkg
// Widths, codes, types and limits of the quad projection block.
// ----------------------------------------------------------------------------
package qrp_pkg;

  localparam int COORD_W    = 16;  // projected screen coordinate
  localparam int VTX_W      = 16;
  localparam int CORNER_W   = 2;
  localparam int RECT_XW    = 16;
  localparam int RECT_W     = 17;
  localparam int TRIG_W     = 16;
  localparam int VIEW_W     = 16;
  localparam int HALF_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = 2 * TRIG_W;
  localparam int ROT_W      = 19;  // rotated y, z
  localparam int DZ_W       = 20;  // z' + view
  localparam int VC_W       = 36;  // view * coord
  localparam int NUM_W      = 43;  // view * coord * 100
  localparam int DVD_W      = 33;  // |num| / 256
  localparam int DVS_W      = DZ_W;
  localparam int SUM_W      = 35;  // half + signed quotient
  localparam int DCNT_W     = 6;
  localparam int FIFO_DEPTH = 2;
  localparam int NCORNERS   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_COS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HH   = 3'd4;

  localparam logic [CORNER_W-1:0] CORNER_D = 2'd3;

  localparam logic signed [COORD_W-1:0] COORD_HI = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_LO = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    BST_IDLE,
    BST_ROT,
    BST_SUM,
    BST_MUL,
    BST_SCALE,
    BST_DIV,
    BST_PROJ,
    BST_DONE
  } back_st_e;

  typedef struct packed {
    logic signed [VTX_W-1:0] vertex_x;
    logic signed [VTX_W-1:0] vertex_y;
    logic signed [VTX_W-1:0] vertex_z;
    logic [CORNER_W-1:0]     corner;
  } vtx_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/qrp_if.sv]
// ----------------------------------------------------------------------------
// qrp_if
// Valid/ready channels: vertex items in, rectangle items out.
// ----------------------------------------------------------------------------
interface qrp_vtx_if;
  import qrp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VTX_W-1:0] vertex_x;
  logic signed [VTX_W-1:0] vertex_y;
  logic signed [VTX_W-1:0] vertex_z;
  logic [CORNER_W-1:0]     corner;

  modport source(output valid, vertex_x, vertex_y, vertex_z, corner, input ready);
  modport sink(input valid, vertex_x, vertex_y, vertex_z, corner, output ready);
endinterface

interface qrp_rect_if;
  import qrp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [RECT_XW-1:0] rect_x;
  logic signed [RECT_XW-1:0] rect_y;
  logic signed [RECT_W-1:0]  rect_w;
  logic signed [RECT_W-1:0]  rect_h;
  logic                      divide_fault;

  modport source(output valid, rect_x, rect_y, rect_w, rect_h, divide_fault,
                 input ready);
  modport sink(input valid, rect_x, rect_y, rect_w, rect_h, divide_fault,
               output ready);
endinterface

[rtl/quad_rotate_project_bbox.sv]
// ----------------------------------------------------------------------------
// quad_rotate_project_bbox
// Rotates quad corners about X, projects them, emits the screen rectangle.
// ----------------------------------------------------------------------------
// Flow: per vertex the back end runs the 33-step divider once for x and once for
// y (skipped when the divisor is zero); the rectangle is registered when corner D
// completes. A new vertex is taken only when the back end is idle again. Two
// vertices queue ahead of the back end.
// Reset: configuration to its defaults, stored corners cleared, queue empty.
module quad_rotate_project_bbox (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  qrp_vtx_if.sink                        vtx,
  qrp_rect_if.source                     rect,
  input  logic                           cfg_we_i,
  input  logic [qrp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [qrp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import qrp_pkg::*;

  // front -> back hand-off
  vtx_item_t item;
  logic      item_valid;
  logic      item_pop;

  // back <-> shared divider
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  // queue of accepted vertices
  qrp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vtx          (vtx),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // rotate, project, keep corners, build rectangle
  qrp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .rect         (rect)
  );

  // one divide per coordinate
  qrp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

[rtl/qrp_front.sv]
// ----------------------------------------------------------------------------
// qrp_front
// Accepts vertex items into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module qrp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  qrp_vtx_if.sink            vtx,
  output qrp_pkg::vtx_item_t item_o,
  output logic               item_valid_o,
  input  logic               item_pop_i
);
  import qrp_pkg::*;

  vtx_item_t  mem_q [FIFO_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign vtx.ready    = (cnt_q != 2'(FIFO_DEPTH));
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];
  assign push         = vtx.valid && vtx.ready;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{vertex_x: vtx.vertex_x, vertex_y: vtx.vertex_y,
                       vertex_z: vtx.vertex_z, corner: vtx.corner};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/qrp_div.sv]
// ----------------------------------------------------------------------------
// qrp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qrp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qrp_pkg::div_req_t req_i,
  output qrp_pkg::div_rsp_t rsp_o
);
  import qrp_pkg::*;

  logic [DVD_W-1:0]  dvd_q;   // dividend shifts out, quotient shifts in
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W+1:0]  diff;
  logic              ge;

  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[DVS_W+1];

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/qrp_back.sv]
// ----------------------------------------------------------------------------
// qrp_back
// Rotates and projects one vertex, keeps corners, emits the rectangle.
// ----------------------------------------------------------------------------
module qrp_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  qrp_pkg::vtx_item_t               item_i,
  input  logic                             item_valid_i,
  output logic                             item_pop_o,
  input  logic                             cfg_we_i,
  input  logic [qrp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [qrp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output qrp_pkg::div_req_t                div_req_o,
  input  qrp_pkg::div_rsp_t                div_rsp_i,
  qrp_rect_if.source                       rect
);
  import qrp_pkg::*;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = $signed({{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return COORD_HI;
    if (v < lo) return COORD_LO;
    return v[COORD_W-1:0];
  endfunction

  back_st_e st_q, st_d;

  // configuration
  logic signed [TRIG_W-1:0] cos_q, sin_q;
  logic [VIEW_W-1:0]        view_q;
  logic [HALF_W-1:0]        hw_q, hh_q;

  // current vertex
  logic signed [VTX_W-1:0]  x_q, y_q, z_q;
  logic [CORNER_W-1:0]      corner_q;
  logic signed [PROD_W-1:0] p_cy_q, p_sz_q, p_sy_q, p_cz_q;
  logic signed [ROT_W-1:0]  yr_q;
  logic signed [DZ_W-1:0]   dz_q;
  logic signed [VC_W-1:0]   vc_q;
  logic                     num_neg_q, num_zero_q;
  logic                     sel_q;       // 0: x, 1: y
  logic                     cur_fault_q;
  logic signed [COORD_W-1:0] px_q, py_q;

  // corners A, B, C
  logic signed [COORD_W-1:0] cx_q [NCORNERS];
  logic signed [COORD_W-1:0] cy_q [NCORNERS];
  logic                      cf_q [NCORNERS];

  // output register
  logic                      rect_valid_q;
  logic signed [RECT_XW-1:0] rx_q, ry_q;
  logic signed [RECT_W-1:0]  rw_q, rh_q;
  logic                      rf_q;

  logic start, load_rect, store_corner, dz_zero;
  logic [PROD_W:0]           ydiff, zsum;
  logic signed [ROT_W-1:0]   coord;
  logic signed [NUM_W-1:0]   vcx, num, mag;
  logic [DVS_W-1:0]          dz_mag;
  logic [HALF_W-1:0]         half;
  logic signed [SUM_W-1:0]   h_ext, q_mag, q_s, psum;
  logic signed [COORD_W-1:0] proj;
  logic signed [COORD_W-1:0] rx, ry, mx, my;
  logic signed [COORD_W:0]   rw_full, rh_full;

  assign dz_zero = (dz_q == '0);

  // rotation sums, floor by 2^14 is a plain bit select
  assign ydiff = {p_cy_q[PROD_W-1], p_cy_q} - {p_sz_q[PROD_W-1], p_sz_q};
  assign zsum  = {p_sy_q[PROD_W-1], p_sy_q} + {p_cz_q[PROD_W-1], p_cz_q};

  assign coord = sel_q ? yr_q : {{(ROT_W-VTX_W){x_q[VTX_W-1]}}, x_q};

  // times 100 = 64 + 32 + 4
  assign vcx = {{(NUM_W-VC_W){vc_q[VC_W-1]}}, vc_q};
  assign num = (vcx <<< 6) + (vcx <<< 5) + (vcx <<< 2);
  assign mag = num[NUM_W-1] ? -num : num;
  assign dz_mag = dz_q[DZ_W-1] ? DVS_W'(-dz_q) : DVS_W'(dz_q);

  assign div_req_o.start    = start;
  assign div_req_o.dividend = mag[DVD_W+7:8];
  assign div_req_o.divisor  = dz_mag;

  // projection result
  assign half  = sel_q ? hh_q : hw_q;
  assign h_ext = $signed({{(SUM_W-HALF_W){1'b0}}, half});
  assign q_mag = $signed({{(SUM_W-DVD_W){1'b0}}, div_rsp_i.quot});
  assign q_s   = (num_neg_q ^ dz_q[DZ_W-1]) ? -q_mag : q_mag;
  assign psum  = h_ext + q_s;

  always_comb begin
    if (!dz_zero)        proj = sat_coord(psum);
    else if (num_zero_q) proj = sat_coord(h_ext);
    else if (num_neg_q)  proj = COORD_LO;
    else                 proj = COORD_HI;
  end

  // rectangle from stored A, B, C and current D
  assign rx = (cx_q[0] < cx_q[1]) ? cx_q[0] : cx_q[1];
  assign ry = (cy_q[0] < py_q) ? cy_q[0] : py_q;
  assign mx = (cx_q[2] > cx_q[1]) ? cx_q[2] : cx_q[1];
  assign my = (cy_q[2] > py_q) ? cy_q[2] : py_q;
  assign rw_full = {mx[COORD_W-1], mx} - {rx[COORD_W-1], rx};
  assign rh_full = {my[COORD_W-1], my} - {ry[COORD_W-1], ry};

  always_comb begin
    st_d         = st_q;
    item_pop_o   = 1'b0;
    start        = 1'b0;
    load_rect    = 1'b0;
    store_corner = 1'b0;
    case (st_q)
      BST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          st_d       = BST_ROT;
        end
      end
      BST_ROT:  st_d = BST_SUM;
      BST_SUM:  st_d = BST_MUL;
      BST_MUL:  st_d = BST_SCALE;
      BST_SCALE: begin
        if (dz_zero) begin
          st_d = BST_PROJ;
        end else begin
          start = 1'b1;
          st_d  = BST_DIV;
        end
      end
      BST_DIV: begin
        if (div_rsp_i.done) st_d = BST_PROJ;
      end
      BST_PROJ: st_d = sel_q ? BST_DONE : BST_MUL;
      BST_DONE: begin
        if (corner_q != CORNER_D) begin
          store_corner = 1'b1;
          st_d         = BST_IDLE;
        end else if (!rect_valid_q || rect.ready) begin
          load_rect = 1'b1;
          st_d      = BST_IDLE;
        end
      end
      default: st_d = BST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      x_q      <= item_i.vertex_x;
      y_q      <= item_i.vertex_y;
      z_q      <= item_i.vertex_z;
      corner_q <= item_i.corner;
    end
    if (st_q == BST_ROT) begin
      p_cy_q <= cos_q * y_q;
      p_sz_q <= sin_q * z_q;
      p_sy_q <= sin_q * y_q;
      p_cz_q <= cos_q * z_q;
    end
    if (st_q == BST_SUM) begin
      yr_q <= $signed(ydiff[PROD_W:14]);
      dz_q <= $signed({zsum[PROD_W], zsum[PROD_W:14]}) + $signed({4'b0000, view_q});
    end
    if (st_q == BST_MUL) begin
      vc_q <= $signed({1'b0, view_q}) * coord;
    end
    if (st_q == BST_SCALE) begin
      num_neg_q  <= vc_q[VC_W-1];
      num_zero_q <= (vc_q == '0);
    end
    if (st_q == BST_PROJ) begin
      if (sel_q) py_q <= proj;
      else       px_q <= proj;
    end
    if (load_rect) begin
      rx_q <= RECT_XW'(rx);
      ry_q <= RECT_XW'(ry);
      rw_q <= RECT_W'(rw_full);
      rh_q <= RECT_W'(rh_full);
      rf_q <= cf_q[0] | cf_q[1] | cf_q[2] | cur_fault_q;
    end
  end

  // control, configuration and corner store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= BST_IDLE;
      sel_q        <= 1'b0;
      cur_fault_q  <= 1'b0;
      rect_valid_q <= 1'b0;
      cos_q        <= 16'sd16384;
      sin_q        <= '0;
      view_q       <= 16'd256;
      hw_q         <= 12'd320;
      hh_q         <= 12'd240;
      for (int i = 0; i < NCORNERS; i++) begin
        cx_q[i] <= '0;
        cy_q[i] <= '0;
        cf_q[i] <= 1'b0;
      end
    end else begin
      st_q <= st_d;
      if (item_pop_o) begin
        sel_q       <= 1'b0;
        cur_fault_q <= 1'b0;
      end else if (st_q == BST_PROJ) begin
        sel_q <= 1'b1;
        if (dz_zero) cur_fault_q <= 1'b1;
      end
      if (store_corner) begin
        cx_q[corner_q] <= px_q;
        cy_q[corner_q] <= py_q;
        cf_q[corner_q] <= cur_fault_q;
      end
      if (load_rect)        rect_valid_q <= 1'b1;
      else if (rect.ready)  rect_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COS:  cos_q  <= cfg_data_i;
          CFG_SIN:  sin_q  <= cfg_data_i;
          CFG_VIEW: view_q <= cfg_data_i;
          CFG_HW:   hw_q   <= cfg_data_i[HALF_W-1:0];
          CFG_HH:   hh_q   <= cfg_data_i[HALF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign rect.valid        = rect_valid_q;
  assign rect.rect_x       = rx_q;
  assign rect.rect_y       = ry_q;
  assign rect.rect_w       = rw_q;
  assign rect.rect_h       = rh_q;
  assign rect.divide_fault = rf_q;

endmodule

[rtl/qrp_checker.sv]
// ----------------------------------------------------------------------------
// qrp_checker
// Port-level checks on the rectangle channel.
// ----------------------------------------------------------------------------
`include "quad_rotate_project_bbox_defines.svh"

module qrp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [qrp_pkg::RECT_W-1:0]    rect_w_i,
  input logic [qrp_pkg::RECT_W-1:0]    rect_h_i,
  input logic                          divide_fault_i
);
  import qrp_pkg::*;

  // width and height span a max against a min of a shared corner
  `QRP_ASSERT_IMPLIES(a_w_nonneg, clk_i, rst_ni, out_valid_i && (COORD_W <= 16), !rect_w_i[RECT_W-1])
  `QRP_ASSERT_IMPLIES(a_h_nonneg, clk_i, rst_ni, out_valid_i && (COORD_W <= 16), !rect_h_i[RECT_W-1])
  `QRP_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `QRP_ASSERT_NEXT(a_data_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(rect_w_i) && $stable(divide_fault_i))

endmodule

bind quad_rotate_project_bbox qrp_checker u_qrp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (rect.valid),
  .out_ready_i    (rect.ready),
  .rect_w_i       (rect.rect_w),
  .rect_h_i       (rect.rect_h),
  .divide_fault_i (rect.divide_fault)
);

[verif/quad_rotate_project_bbox_tb.sv]
// ----------------------------------------------------------------------------
// quad_rotate_project_bbox_tb
// Drives quads of vertex items with random gaps, predicts each rectangle from
// a local rotation and projection model and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class rect_scoreboard;
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [16:0] w;
    logic signed [16:0] h;
    logic               fault;
  } rect_t;

  typedef struct {
    longint x;
    longint y;
    bit     fault;
  } proj_t;

  longint rot_cos, rot_sin, view, half_w, half_h;
  proj_t  stored[3];
  rect_t  pending_rects[$];
  int     errors;

  function void clear();
    rot_cos = 16384; rot_sin = 0; view = 256; half_w = 320; half_h = 240;
    foreach (stored[i]) stored[i] = '{0, 0, 0};
    pending_rects.delete();
    errors = 0;
  endfunction

  function void set_reg(int idx, logic [15:0] val);
    case (idx)
      qrp_pkg::CFG_COS:  rot_cos = longint'($signed(val));
      qrp_pkg::CFG_SIN:  rot_sin = longint'($signed(val));
      qrp_pkg::CFG_VIEW: view    = longint'(val);
      qrp_pkg::CFG_HW:   half_w  = longint'(val[11:0]);
      qrp_pkg::CFG_HH:   half_h  = longint'(val[11:0]);
      default: ;
    endcase
  endfunction

  // floor division by 2^14
  function longint floor14(longint v);
    if (v >= 0) return v >>> 14;
    return -((-v + 16383) >>> 14);
  endfunction

  function longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function longint project(longint c, longint zr, longint half, inout bit fault);
    longint num, den;
    num = view * c * 100;
    den = 256 * (zr + view);
    if (den == 0) begin
      fault = 1;
      if (num > 0) return 32767;
      if (num < 0) return -32768;
      return clamp16(half);
    end
    return clamp16(half + num / den);   // SV '/' truncates toward zero
  endfunction

  function void note_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                            logic signed [15:0] vz, logic [1:0] corner);
    longint yr, zr, rx, ry, mx, my;
    proj_t  cur;
    rect_t  r;
    yr = floor14(rot_cos * vy - rot_sin * vz);
    zr = floor14(rot_sin * vy + rot_cos * vz);
    cur.fault = 0;
    cur.x = project(vx, zr, half_w, cur.fault);
    cur.y = project(yr, zr, half_h, cur.fault);
    if (corner != qrp_pkg::CORNER_D) begin
      stored[corner] = cur;
      return;
    end
    rx = stored[0].x < stored[1].x ? stored[0].x : stored[1].x;
    ry = stored[0].y < cur.y ? stored[0].y : cur.y;
    mx = stored[2].x > stored[1].x ? stored[2].x : stored[1].x;
    my = stored[2].y > cur.y ? stored[2].y : cur.y;
    r.x = rx[15:0];
    r.y = ry[15:0];
    r.w = 17'(mx - rx);
    r.h = 17'(my - ry);
    r.fault = stored[0].fault | stored[1].fault | stored[2].fault | cur.fault;
    pending_rects.push_back(r);
  endfunction

  function void check_rect(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [16:0] w, logic signed [16:0] h,
                           logic fault);
    rect_t e;
    if (pending_rects.size() == 0) begin
      $display("%0t: unexpected rect x=%0d y=%0d w=%0d h=%0d", $time, x, y, w, h);
      errors++;
      return;
    end
    e = pending_rects.pop_front();
    if (x !== e.x) begin
      $display("%0t: rect_x exp %0d got %0d", $time, e.x, x); errors++;
    end
    if (y !== e.y) begin
      $display("%0t: rect_y exp %0d got %0d", $time, e.y, y); errors++;
    end
    if (w !== e.w) begin
      $display("%0t: rect_w exp %0d got %0d", $time, e.w, w); errors++;
    end
    if (h !== e.h) begin
      $display("%0t: rect_h exp %0d got %0d", $time, e.h, h); errors++;
    end
    if (fault !== e.fault) begin
      $display("%0t: divide_fault exp %0b got %0b", $time, e.fault, fault);
      errors++;
    end
  endfunction
endclass

module quad_rotate_project_bbox_tb;
  import qrp_pkg::*;

  localparam int WATCHDOG = 20000;   // idle cycles allowed: one vertex + long gaps
  localparam int DRAIN    = 400;     // settle after last rect: up to three vertices

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  qrp_vtx_if  vtx();
  qrp_rect_if rect();

  rect_scoreboard sb;
  int  idle_cycles;

  always #5 clk_i = ~clk_i;

  quad_rotate_project_bbox dut (
    .clk_i, .rst_ni, .vtx(vtx.sink), .rect(rect.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    vtx.valid = 1'b0;
    vtx.vertex_x = '0; vtx.vertex_y = '0; vtx.vertex_z = '0; vtx.corner = '0;
    rect.ready = 1'b0;
  end

  // Gap length: mostly 0..3, sometimes up to 60.
  function automatic int gap_len();
    if ($urandom_range(9) < 7) return $urandom_range(3);
    return $urandom_range(60);
  endfunction

  // Sample both handshakes at the edge; prediction happens here so ordering
  // inside the time step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (vtx.valid && vtx.ready)
        sb.note_vertex(vtx.vertex_x, vtx.vertex_y, vtx.vertex_z, vtx.corner);
      if (rect.valid && rect.ready)
        sb.check_rect(rect.rect_x, rect.rect_y, rect.rect_w, rect.rect_h,
                      rect.divide_fault);
      if ((vtx.valid && vtx.ready) || (rect.valid && rect.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: random stalls, with quiet stretches of always-ready.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(7) == 0) begin
        g = gap_len();
        if (g > 0) begin
          rect.ready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
      rect.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Wait until all rects arrived, then let the back end finish any A/B/C.
  task automatic wait_idle();
    vtx.valid <= 1'b0;
    while (sb.pending_rects.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // valid stays up after acceptance so items can go back to back; it drops
  // at the start of a gap or in wait_idle
  task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [1:0] c);
    int g;
    g = ($urandom_range(3) == 0) ? gap_len() : 0;
    if (g > 0) begin
      vtx.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    vtx.valid    <= 1'b1;
    vtx.vertex_x <= x;
    vtx.vertex_y <= y;
    vtx.vertex_z <= z;
    vtx.corner   <= c;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
  endtask

  // Coordinates biased toward extremes, small values and plain random.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_quad();
    for (int c = 0; c < 4; c++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), c[1:0]);
  endtask

  task automatic random_config(input int mode);
    logic [15:0] cv, sv, vv;
    case (mode)
      0: begin cv = 16'sd16384;  sv = 16'sd0;      end
      1: begin cv = -16'sd16384; sv = 16'sd0;      end
      2: begin cv = 16'sd0;      sv = 16'sd16384;  end
      3: begin cv = 16'sd0;      sv = -16'sd16384; end
      default: begin
        cv = 16'($signed($urandom_range(32768)) - 16384);
        sv = 16'($signed($urandom_range(32768)) - 16384);
      end
    endcase
    case ($urandom_range(3))
      0: vv = 16'd1;
      1: vv = 16'hffff;
      default: vv = 16'($urandom_range(65535, 1));
    endcase
    write_reg(CFG_COS, cv);
    write_reg(CFG_SIN, sv);
    write_reg(CFG_VIEW, vv);
    write_reg(CFG_HW, ($urandom_range(3) == 0) ? 16'hfff : 16'($urandom_range(4095)));
    write_reg(CFG_HH, ($urandom_range(3) == 0) ? 16'h000 : 16'($urandom_range(4095)));
  endtask

  initial begin
    int sent;
    sb = new();
    sb.clear();
    idle_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config, D with nothing stored yet, extremes.
    send_vertex(16'h0100, 16'h0100, 16'h0000, CORNER_D);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 2'd0);
    send_vertex(16'h8000, 16'h8000, 16'h8000, 2'd1);
    send_vertex(16'h0000, 16'h0000, 16'h0000, 2'd2);
    send_vertex(16'h8000, 16'h7fff, 16'h0000, CORNER_D);
    // Zero divisor: z = -view (256) with cos=1, sin=0; x pos/neg/zero.
    send_vertex(16'h0100, 16'hff00, 16'hff00, 2'd0);
    send_vertex(16'hff00, 16'h0100, 16'hff00, 2'd1);
    send_vertex(16'h0000, 16'h0000, 16'hff00, 2'd2);
    send_vertex(16'h0000, 16'h0000, 16'h0000, CORNER_D);
    // Negative divisor, out of order and repeated corners.
    send_vertex(16'h0200, 16'h0300, 16'h8000, 2'd2);
    send_vertex(16'h0200, 16'h0300, 16'h8000, 2'd2);
    send_vertex(16'hfe00, 16'h0100, 16'hfc00, 2'd1);
    send_vertex(16'h0010, 16'h0020, 16'h0030, CORNER_D);
    send_vertex(16'h1234, 16'h8765, 16'h0f0f, CORNER_D);
    wait_idle();

    // Extreme config: view=1 and max halves, then sin=-1.
    write_reg(CFG_VIEW, 16'd1);
    write_reg(CFG_HW, 16'hfff);
    write_reg(CFG_HH, 16'hfff);
    write_reg(CFG_COS, 16'sd0);
    write_reg(CFG_SIN, -16'sd16384);
    send_quad();
    send_vertex(16'h0000, 16'h0001, 16'h0000, CORNER_D);   // zr+V==0 at y=1
    wait_idle();

    // Random phases: mostly well-ordered quads, some stray corners.
    sent = 0;
    for (int ph = 0; sent < 450; ph++) begin
      random_config(ph % 8);
      for (int q = 0; q < 10; q++) begin
        if ($urandom_range(7) == 0) begin
          send_vertex(16'($urandom), 16'($urandom), 16'($urandom), 2'($urandom));
          sent++;
        end else begin
          send_quad();
          sent += 4;
        end
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending_rects.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
